[sv/qph_pkg.sv]
// -----------------------------------------------------------------------------
// qph_pkg
// Types and constants shared by the quadratic probe hash table core.
// -----------------------------------------------------------------------------
package qph_pkg;

   localparam int NW        = 11;
   localparam int KEY_W     = 32;
   localparam int POS_W     = 10;
   localparam int STAT_W    = 3;
   localparam int RSP_W     = 16;
   localparam int DIGIT_W   = 4;
   localparam int DIGITS    = KEY_W / DIGIT_W;
   localparam int DIG_CNT_W = $clog2(DIGITS);
   localparam int ENTRY_W   = KEY_W + 1;

   typedef logic [NW-1:0] slot_type;

   localparam slot_type SIZE_MIN   = slot_type'(3);
   localparam slot_type SIZE_RESET = slot_type'(29);

   localparam logic OPC_FIND   = 1'b0;
   localparam logic OPC_INSERT = 1'b1;

   localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_ABSENT   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd2;
   localparam logic [STAT_W-1:0] STAT_PRESENT  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_DIV = 2'd2
   } unit_op_type;

   typedef struct packed {
      unit_op_type          op;
      slot_type             a;
      slot_type             b;
      logic [DIGIT_W-1:0]   digit;
   } unit_cmd_type;

endpackage

[sv/qph_modunit.sv]
// -----------------------------------------------------------------------------
// qph_modunit
// Shared modular arithmetic unit: add and subtract modulo the table size,
// and a four-bit remainder step for the home slot division.
// -----------------------------------------------------------------------------
module qph_modunit (
   input  qph_pkg::unit_cmd_type cmd,
   input  qph_pkg::slot_type     n,
   output qph_pkg::slot_type     res
);

   logic [qph_pkg::NW:0] sum;
   logic [qph_pkg::NW:0] dif;
   logic [qph_pkg::NW:0] wrap;
   logic [qph_pkg::NW:0] nx;
   logic [qph_pkg::NW:0] t;
   qph_pkg::slot_type    rem;

   always_comb begin
      nx   = {1'b0, n};
      sum  = {1'b0, cmd.a} + {1'b0, cmd.b};
      dif  = {1'b0, cmd.a} - {1'b0, cmd.b};
      wrap = dif + nx;
      rem  = cmd.a;
      t    = '0;
      for (int i = qph_pkg::DIGIT_W - 1; i >= 0; i--) begin
         t = {rem, cmd.digit[i]};
         if (t >= nx) begin
            t = t - nx;
         end
         rem = t[qph_pkg::NW-1:0];
      end
      unique case (cmd.op)
         qph_pkg::OP_ADD: begin
            if (sum >= nx) begin
               res = qph_pkg::slot_type'(sum - nx);
            end else begin
               res = sum[qph_pkg::NW-1:0];
            end
         end
         qph_pkg::OP_SUB: begin
            if (dif[qph_pkg::NW]) begin
               res = wrap[qph_pkg::NW-1:0];
            end else begin
               res = dif[qph_pkg::NW-1:0];
            end
         end
         qph_pkg::OP_DIV: res = rem;
         default:         res = cmd.a;
      endcase
   end

endmodule

[sv/qph_slot_ram.sv]
// -----------------------------------------------------------------------------
// qph_slot_ram
// Slot memory: one used bit and one key per slot, one write and one
// registered read per cycle.
// -----------------------------------------------------------------------------
module qph_slot_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [ADDR_W-1:0]                waddr,
   input  logic [qph_pkg::ENTRY_W-1:0]      wdata,
   input  logic [ADDR_W-1:0]                raddr,
   output logic [qph_pkg::ENTRY_W-1:0]      rdata
);

   logic [qph_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [qph_pkg::ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/quadratic_probe_hash_table_core.sv]
// -----------------------------------------------------------------------------
// quadratic_probe_hash_table_core
// Open-addressing hash table of 32-bit keys with quadratic probing
// (+1, -1, +4, -4, ...) modulo a configurable prime table size.
//
//   port group  dir  tdata / tuser contents (lsb first)
//   req_*       in   tdata: key[31:0]; tuser: opcode (0 find, 1 insert)
//   rsp_*       out  tdata: position[9:0], status[12:10], zero pad
//   csr_*       in   csr_wdata: table_size[10:0]
//
// after reset a clearing pass empties every slot with req_tready low
// home slot: computed in the shared modular unit, 4 key bits per cycle
// each probe: a memory read (S_READ) and a compare (S_CHECK), plus the S_ODD and
// S_PLUS states to step the square before every positive probe
// an item hitting at its home slot goes through S_HOME, S_READ, S_CHECK, S_DONE to idle
// a finished result waits in the rsp register; the core stalls only if it is
// still full when the next result is ready
// -----------------------------------------------------------------------------
module quadratic_probe_hash_table_core #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key[31:0]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // position[9:0], status[12:10]
   input  logic        csr_we,
   input  logic [10:0] csr_wdata    // table_size[10:0]
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int CAP = (TABLE_DEPTH < 2047) ? TABLE_DEPTH : 2047;
   localparam qph_pkg::slot_type SIZE_CAP = qph_pkg::slot_type'(CAP);
   localparam logic [AW-1:0]     CLR_LAST = AW'(TABLE_DEPTH - 1);
   localparam logic [qph_pkg::DIG_CNT_W-1:0] DIG_LAST =
      qph_pkg::DIG_CNT_W'(qph_pkg::DIGITS - 1);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_HOME  = 8'b0000_0100,
      S_READ  = 8'b0000_1000,
      S_CHECK = 8'b0001_0000,
      S_ODD   = 8'b0010_0000,
      S_PLUS  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type                           state_ff, state_in;
   qph_pkg::slot_type                   table_size_ff, table_size_in;
   logic [AW-1:0]                       clr_ff, clr_in;
   logic                                op_ff, op_in;
   logic [qph_pkg::KEY_W-1:0]           key_ff, key_in;
   logic [qph_pkg::KEY_W-1:0]           div_sh_ff, div_sh_in;
   logic [qph_pkg::DIG_CNT_W-1:0]       dig_ff, dig_in;
   qph_pkg::slot_type                   home_ff, home_in;
   qph_pkg::slot_type                   pos_ff, pos_in;
   qph_pkg::slot_type                   sq_ff, sq_in;
   qph_pkg::slot_type                   odd_ff, odd_in;
   qph_pkg::slot_type                   cnt_ff, cnt_in;
   logic [qph_pkg::STAT_W-1:0]          stat_ff, stat_in;
   logic                                store_ff, store_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [qph_pkg::POS_W-1:0]           rsp_pos_ff, rsp_pos_in;
   logic [qph_pkg::STAT_W-1:0]          rsp_stat_ff, rsp_stat_in;

   qph_pkg::slot_type                   n_eff;
   qph_pkg::slot_type                   cnt_inc;
   qph_pkg::unit_cmd_type               ucmd;
   qph_pkg::slot_type                   ures;
   logic                                mem_we;
   logic [AW-1:0]                       mem_waddr;
   logic [qph_pkg::ENTRY_W-1:0]         mem_wdata;
   logic [qph_pkg::ENTRY_W-1:0]         mem_rdata;
   logic                                rd_used;
   logic                                hit;
   logic                                rsp_free;

   qph_modunit u_unit (
      .cmd (ucmd),
      .n   (n_eff),
      .res (ures)
   );

   qph_slot_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (AW'(pos_ff)),
      .rdata (mem_rdata)
   );

   // effective size, clamped to the supported range
   always_comb begin
      if (table_size_ff < qph_pkg::SIZE_MIN) begin
         n_eff = qph_pkg::SIZE_MIN;
      end else if (table_size_ff > SIZE_CAP) begin
         n_eff = SIZE_CAP;
      end else begin
         n_eff = table_size_ff;
      end
   end

   assign cnt_inc  = cnt_ff + qph_pkg::slot_type'(1);
   assign rd_used  = mem_rdata[qph_pkg::KEY_W];
   assign hit      = !rd_used || (mem_rdata[qph_pkg::KEY_W-1:0] == key_ff);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(qph_pkg::RSP_W - qph_pkg::POS_W - qph_pkg::STAT_W){1'b0}},
                        rsp_stat_ff, rsp_pos_ff};

   // shared unit command
   always_comb begin
      ucmd.op    = qph_pkg::OP_ADD;
      ucmd.a     = '0;
      ucmd.b     = '0;
      ucmd.digit = '0;
      unique case (state_ff)
         S_HOME: begin
            ucmd.op    = qph_pkg::OP_DIV;
            ucmd.a     = home_ff;
            ucmd.digit = div_sh_ff[qph_pkg::KEY_W-1 -: qph_pkg::DIGIT_W];
         end
         S_CHECK: begin
            if (cnt_ff[0]) begin
               ucmd.op = qph_pkg::OP_SUB;
               ucmd.a  = home_ff;
               ucmd.b  = sq_ff;
            end else begin
               ucmd.a = sq_ff;
               ucmd.b = odd_ff;
            end
         end
         S_ODD: begin
            ucmd.a = odd_ff;
            ucmd.b = qph_pkg::slot_type'(2);
         end
         S_PLUS: begin
            ucmd.a = home_ff;
            ucmd.b = sq_ff;
         end
         default: begin
            ucmd.a = '0;
         end
      endcase
   end

   // slot memory write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(pos_ff);
      mem_wdata = {1'b1, key_ff};
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if ((state_ff == S_DONE) && rsp_free && store_ff) begin
         mem_we = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      table_size_in = table_size_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      div_sh_in     = div_sh_ff;
      dig_in        = dig_ff;
      home_in       = home_ff;
      pos_in        = pos_ff;
      sq_in         = sq_ff;
      odd_in        = odd_ff;
      cnt_in        = cnt_ff;
      stat_in       = stat_ff;
      store_in      = store_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_stat_in   = rsp_stat_ff;

      if (csr_we) begin
         table_size_in = csr_wdata;
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               key_in    = req_tdata;
               div_sh_in = req_tdata;
               home_in   = '0;
               dig_in    = '0;
               state_in  = S_HOME;
            end
         end
         S_HOME: begin
            home_in   = ures;
            div_sh_in = div_sh_ff << qph_pkg::DIGIT_W;
            dig_in    = dig_ff + qph_pkg::DIG_CNT_W'(1);
            if (dig_ff == DIG_LAST) begin
               pos_in   = ures;
               cnt_in   = '0;
               sq_in    = '0;
               odd_in   = qph_pkg::slot_type'(1);
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit) begin
               store_in = !rd_used && (op_ff == qph_pkg::OPC_INSERT);
               state_in = S_DONE;
               if (rd_used) begin
                  stat_in = (op_ff == qph_pkg::OPC_INSERT) ? qph_pkg::STAT_PRESENT
                                                           : qph_pkg::STAT_FOUND;
               end else begin
                  stat_in = (op_ff == qph_pkg::OPC_INSERT) ? qph_pkg::STAT_INSERTED
                                                           : qph_pkg::STAT_ABSENT;
               end
            end else if (cnt_inc == n_eff) begin
               stat_in  = qph_pkg::STAT_FULL;
               store_in = 1'b0;
               pos_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_inc;
               if (cnt_ff[0]) begin
                  pos_in   = ures;
                  state_in = S_READ;
               end else begin
                  sq_in    = ures;
                  state_in = S_ODD;
               end
            end
         end
         S_ODD: begin
            odd_in   = ures;
            state_in = S_PLUS;
         end
         S_PLUS: begin
            pos_in   = ures;
            state_in = S_READ;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff[qph_pkg::POS_W-1:0];
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         table_size_ff <= qph_pkg::SIZE_RESET;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      div_sh_ff   <= div_sh_in;
      dig_ff      <= dig_in;
      home_ff     <= home_in;
      pos_ff      <= pos_in;
      sq_ff       <= sq_in;
      odd_ff      <= odd_in;
      cnt_ff      <= cnt_in;
      stat_ff     <= stat_in;
      store_ff    <= store_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_stat_ff <= rsp_stat_in;
   end

`ifndef ASSERT_OFF
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (pos_ff < n_eff))
      else $error("probe slot outside table");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (cnt_ff < n_eff))
      else $error("probe count reached table size");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ODD || state_ff == S_PLUS) |-> (sq_ff < n_eff && odd_ff < n_eff))
      else $error("square step not reduced");

   a_store_only_insert: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff != S_CLEAR) |->
         (state_ff == S_DONE && stat_ff == qph_pkg::STAT_INSERTED))
      else $error("slot written without insert");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_HOME))
      else $error("accepted transaction did not start home slot");
`endif

endmodule

[test/qph_lookup_checker.sv]
// -----------------------------------------------------------------------------
// qph_lookup_checker
// Watches the request, response and csr channels of the quadratic probe hash
// table core. It keeps its own copy of the slot table and the table size,
// works out the slot and status of every accepted request, and compares each
// response transaction field by field against the oldest pending lookup.
// -----------------------------------------------------------------------------
module qph_lookup_checker #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   output int          pending,
   output int          fail_count
);

   typedef struct packed {
      logic [qph_pkg::STAT_W-1:0] status;
      logic [qph_pkg::POS_W-1:0]  position;
   } lookup_result_type;

   qph_pkg::slot_type         size_reg;
   logic                      slot_taken [TABLE_DEPTH];
   logic [qph_pkg::KEY_W-1:0] slot_keys  [TABLE_DEPTH];
   lookup_result_type         expected_lookups [$];

   // walk the +1, -1, +4, -4 ... sequence and update the table copy
   function automatic lookup_result_type predict_lookup(
      input logic                      opcode,
      input logic [qph_pkg::KEY_W-1:0] key);
      int unsigned       n;
      int unsigned       home;
      int unsigned       step;
      int unsigned       half;
      int unsigned       off;
      int unsigned       pos;
      bit                hit;
      lookup_result_type r;
      n = size_reg;
      if (n < qph_pkg::SIZE_MIN) n = qph_pkg::SIZE_MIN;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      home = key % n;
      hit  = 1'b0;
      pos  = 0;
      for (step = 0; step < n && !hit; step++) begin
         half = (step + 1) / 2;
         off  = (half * half) % n;
         pos  = step[0] ? (home + off) % n : (home + n - off) % n;
         hit  = !slot_taken[pos] || slot_keys[pos] == key;
      end
      r.position = pos[qph_pkg::POS_W-1:0];
      if (!hit) begin
         r.position = '0;
         r.status   = qph_pkg::STAT_FULL;
      end else if (slot_taken[pos]) begin
         r.status = (opcode == qph_pkg::OPC_INSERT) ? qph_pkg::STAT_PRESENT
                                                    : qph_pkg::STAT_FOUND;
      end else if (opcode == qph_pkg::OPC_INSERT) begin
         slot_taken[pos] = 1'b1;
         slot_keys[pos]  = key;
         r.status        = qph_pkg::STAT_INSERTED;
      end else begin
         r.status = qph_pkg::STAT_ABSENT;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_result_type got;
      lookup_result_type want;
      if (reset) begin
         size_reg   = qph_pkg::SIZE_RESET;
         fail_count = 0;
         foreach (slot_taken[i]) slot_taken[i] = 1'b0;
         expected_lookups.delete();
      end else begin
         if (csr_we) size_reg = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[qph_pkg::POS_W+qph_pkg::STAT_W-1:0];
            if (expected_lookups.size() == 0) begin
               $error("unexpected response transaction: position %0d, status %0d",
                      got.position, got.status);
               fail_count++;
            end else begin
               want = expected_lookups.pop_front();
               if (got.position !== want.position) begin
                  $error("position mismatch: expected %0d, got %0d",
                         want.position, got.position);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d",
                         want.status, got.status);
                  fail_count++;
               end
               if (rsp_tdata[qph_pkg::RSP_W-1:qph_pkg::POS_W+qph_pkg::STAT_W] !== '0)
               begin
                  $error("pad mismatch: expected 0, got %0d",
                         rsp_tdata[qph_pkg::RSP_W-1:qph_pkg::POS_W+qph_pkg::STAT_W]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_lookups.push_back(predict_lookup(req_tuser, req_tdata));
      end
      pending = expected_lookups.size();
   end

endmodule

[test/quadratic_probe_hash_table_core_tb.sv]
// -----------------------------------------------------------------------------
// quadratic_probe_hash_table_core_tb
// Drives find and insert transactions into the hash table core: a directed
// pass over collisions, wrap-around, key extremes, a full table and the
// out-of-range sizes, then random phases over many table sizes with keys
// drawn so that hits, collisions and misses all occur. The sender idles in
// bursts, the receiver stalls on its own pattern with long hold-offs, and
// qph_lookup_checker predicts and compares every response.
// -----------------------------------------------------------------------------
module quadratic_probe_hash_table_core_tb;

   localparam int TABLE_DEPTH  = 1024;
   localparam int ITEM_TARGET  = 1500;
   localparam int POOL_DEPTH   = 256;
   localparam int SIZE_COUNT   = 22;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = qph_pkg::OPC_FIND;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [10:0] csr_wdata  = '0;

   int          pending;
   int          fail_count;
   int          burst_left = 0;
   int          issued     = 0;
   bit          steady     = 1'b0;
   int unsigned size_now   = qph_pkg::SIZE_RESET;
   logic [31:0] key_pool [$];

   int          results_seen = 0;
   int          hold_cycles  = 0;
   int          holds_done   = 0;
   int          mode_left    = 0;
   rx_mode_type stall_mode   = RX_OPEN;

   int random_sizes [SIZE_COUNT] = '{5, 1024, 13, 3, 61, 2047, 7, 31, 0, 1021, 11,
                                     127, 2, 251, 17, 509, 101, 19, 1019, 23, 37, 43};

   quadratic_probe_hash_table_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   qph_lookup_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .fail_count(fail_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("quadratic_probe_hash_table_core_tb NOT OK");
      $finish;
   end

   // response side: changing stall pattern plus long hold-offs while requests wait
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) results_seen++;
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (holds_done < 2 && req_tvalid &&
                      results_seen >= 250 + holds_done * 700) begin
            holds_done++;
            hold_cycles = 400;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= (mode_left % 4 == 0);
               default:   rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_lookup(input logic opcode, input logic [31:0] key);
      int gap;
      if (burst_left == 0) begin
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= opcode;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      issued++;
      if (opcode == qph_pkg::OPC_INSERT) begin
         key_pool.push_back(key);
         if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_table_size(input logic [10:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      size_now = value;
      if (size_now < qph_pkg::SIZE_MIN) size_now = qph_pkg::SIZE_MIN;
      if (size_now > TABLE_DEPTH) size_now = TABLE_DEPTH;
   endtask

   // mix of stored keys, keys sharing a stored key's home slot, and fresh keys
   function automatic logic [31:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35 && key_pool.size() > 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (roll < 55 && key_pool.size() > 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)] +
                $urandom_range(1, 4) * size_now;
      if (roll < 85)
         return $urandom;
      if (roll < 95)
         return $urandom_range(0, 4 * size_now);
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   initial begin
      int phase;
      int count;
      int insert_pct;
      int k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset size: collisions at home, +1, -1 with wrap, +4, -4
      send_lookup(qph_pkg::OPC_INSERT, 32'd0);
      send_lookup(qph_pkg::OPC_INSERT, 32'd29);
      send_lookup(qph_pkg::OPC_INSERT, 32'd58);
      send_lookup(qph_pkg::OPC_INSERT, 32'd87);
      send_lookup(qph_pkg::OPC_FIND,   32'd87);
      send_lookup(qph_pkg::OPC_FIND,   32'd116);
      send_lookup(qph_pkg::OPC_INSERT, 32'd29);
      send_lookup(qph_pkg::OPC_FIND,   32'd0);
      send_lookup(qph_pkg::OPC_INSERT, 32'hFFFF_FFFF);
      send_lookup(qph_pkg::OPC_INSERT, 32'h8000_0000);
      send_lookup(qph_pkg::OPC_INSERT, 32'h7FFF_FFFF);
      send_lookup(qph_pkg::OPC_FIND,   32'hFFFF_FFFF);
      send_lookup(qph_pkg::OPC_FIND,   32'h1234_5678);

      // smallest size, keys left over from before, then a full table
      set_table_size(11'd3);
      send_lookup(qph_pkg::OPC_INSERT, 32'd2);
      send_lookup(qph_pkg::OPC_INSERT, 32'd7);
      send_lookup(qph_pkg::OPC_FIND,   32'd8);
      send_lookup(qph_pkg::OPC_FIND,   32'd0);
      set_table_size(11'd0);
      send_lookup(qph_pkg::OPC_INSERT, 32'd10);
      set_table_size(11'd2);
      send_lookup(qph_pkg::OPC_FIND,   32'd11);

      // size above range acts as the full depth, positions up to 1023
      set_table_size(11'd2047);
      send_lookup(qph_pkg::OPC_INSERT, 32'd1023);
      send_lookup(qph_pkg::OPC_INSERT, 32'hFFFF_FFFF);
      send_lookup(qph_pkg::OPC_FIND,   32'hFFFF_FFFF);
      send_lookup(qph_pkg::OPC_INSERT, 32'd2047);
      send_lookup(qph_pkg::OPC_FIND,   32'h8000_03FF);

      phase = 0;
      while (issued < ITEM_TARGET) begin
         set_table_size(11'(random_sizes[phase % SIZE_COUNT]));
         count      = (size_now > 127) ? 25 : 100;
         insert_pct = $urandom_range(20, 80);
         steady     = ($urandom_range(0, 3) == 0);
         for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 149) == 0) drain_results();
            send_lookup(($urandom_range(0, 99) < insert_pct) ? qph_pkg::OPC_INSERT
                                                             : qph_pkg::OPC_FIND,
                        pick_key());
         end
         phase++;
      end

      drain_results();
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("quadratic_probe_hash_table_core_tb OK");
      end else begin
         $display("quadratic_probe_hash_table_core_tb NOT OK");
      end
      $finish;
   end

endmodule
